// ===== rtl/positional_list_engine_defines.svh =====
// assertion macros for the positional list engine
// used by the top level only, relies on clk and rst in scope
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// property checked at every edge outside reset
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the following cycle
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ple_pkg.sv =====
// shared types and codes for the positional list engine
// no dependencies
package ple_pkg;

  // operation codes carried on s_tuser
  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_ERASE  = 2'd1,
    K_SORT   = 2'd2,
    K_DUMP   = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WR,
    ST_INS_PUT,
    ST_ERA_WR,
    ST_SRT_LDI,
    ST_SRT_CMP,
    ST_SRT_PUT,
    ST_DMP_OUT
  } state_t;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 5;

endpackage

// ===== rtl/positional_list_engine.sv =====
// positional list engine: ordered list of signed values held in one sync memory
// insert shifts each entry at or above position up, erase shifts the entries above it down, sort is an exchange sort,
// dump gives one result per cycle while m_tready is high; one item is worked at a time
// the rate is set by the single read and single write port of the entry memory
// rst clears the count and the sequencer; entry memory has no reset
// depends on ple_pkg and positional_list_engine_defines.svh
`include "positional_list_engine_defines.svh"
module positional_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // accepted[0], full_res[1], has_element[2],
                                 // element[34:3], index[38:35], count[43:39], zero pad
  output logic        m_tlast    // last
);
  import ple_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // entry memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  logic [VAL_W-1:0] wdata;

  // control and working registers
  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    i, i_next, j, j_next;
  logic [POS_W-1:0] pos_r, pos_next;
  logic [VAL_W-1:0] val_r, val_next, cur, cur_next;

  // output register
  logic             out_load, out_acc, out_full, out_has, out_last;
  logic [VAL_W-1:0] out_elem;
  logic [IDX_W-1:0] out_idx;
  logic             o_acc, o_full, o_has, o_last;
  logic [VAL_W-1:0] o_elem;
  logic [IDX_W-1:0] o_idx;
  logic [COUNT_W-1:0] o_cnt;

  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  kind_t            in_kind;
  logic [CMPW-1:0]  pos_w, cnt_w, posr_w;
  logic             out_free;

  assign in_pos   = s_tdata[4:0];
  assign in_val   = s_tdata[36:5];
  assign in_kind  = kind_t'(s_tuser);
  assign pos_w    = CMPW'(in_pos);
  assign posr_w   = CMPW'(pos_r);
  assign cnt_w    = CMPW'(cnt);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && (state == ST_IDLE) && !m_tvalid;

  // memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    i     <= i_next;
    j     <= j_next;
    pos_r <= pos_next;
    val_r <= val_next;
    cur   <= cur_next;
  end

  // next state, memory control and result load
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    i_next     = i;
    j_next     = j;
    pos_next   = pos_r;
    val_next   = val_r;
    cur_next   = cur;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = cur;
    out_load   = 1'b0;
    out_acc    = 1'b1;
    out_full   = 1'b0;
    out_has    = 1'b0;
    out_elem   = '0;
    out_idx    = '0;
    out_last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          pos_next = in_pos;
          val_next = in_val;
          case (in_kind)
            K_INSERT: begin
              if (cnt == CW'(DEPTH)) begin
                out_load = 1'b1;
                out_acc  = 1'b0;
                out_full = 1'b1;
              end else if (pos_w > cnt_w) begin
                out_load = 1'b1;
                out_acc  = 1'b0;
              end else if (pos_w == cnt_w) begin
                state_next = ST_INS_PUT;
              end else begin
                i_next     = cnt;
                re         = 1'b1;
                raddr      = AW'(cnt - 1'b1);
                state_next = ST_INS_WR;
              end
            end
            K_ERASE: begin
              if (pos_w >= cnt_w) begin
                out_load = 1'b1;
                out_acc  = 1'b0;
              end else if (pos_w + 1'b1 == cnt_w) begin
                cnt_next = cnt - 1'b1;
                out_load = 1'b1;
              end else begin
                i_next     = CW'(in_pos);
                re         = 1'b1;
                raddr      = AW'(in_pos + 1'b1);
                state_next = ST_ERA_WR;
              end
            end
            K_SORT: begin
              if (cnt <= CW'(1)) begin
                out_load = 1'b1;
              end else begin
                i_next     = '0;
                re         = 1'b1;
                raddr      = '0;
                state_next = ST_SRT_LDI;
              end
            end
            default: begin
              if (cnt == '0) begin
                out_load = 1'b1;
              end else begin
                i_next     = '0;
                re         = 1'b1;
                raddr      = '0;
                state_next = ST_DMP_OUT;
              end
            end
          endcase
        end
      end
      // shift one entry up, reading the next lower one
      ST_INS_WR: begin
        we     = 1'b1;
        waddr  = AW'(i);
        wdata  = rdata;
        i_next = i - 1'b1;
        if (CMPW'(i - 1'b1) == posr_w) begin
          state_next = ST_INS_PUT;
        end else begin
          re    = 1'b1;
          raddr = AW'(i - 2'd2);
        end
      end
      ST_INS_PUT: begin
        we         = 1'b1;
        waddr      = AW'(pos_r);
        wdata      = val_r;
        cnt_next   = cnt + 1'b1;
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end
      // shift one entry down
      ST_ERA_WR: begin
        we     = 1'b1;
        waddr  = AW'(i);
        wdata  = rdata;
        i_next = i + 1'b1;
        if (i + 2'd2 == cnt) begin
          cnt_next   = cnt - 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          re    = 1'b1;
          raddr = AW'(i + 2'd2);
        end
      end
      // exchange sort: hold the running minimum for slot i
      ST_SRT_LDI: begin
        cur_next   = rdata;
        j_next     = i + 1'b1;
        re         = 1'b1;
        raddr      = AW'(i + 1'b1);
        state_next = ST_SRT_CMP;
      end
      ST_SRT_CMP: begin
        if ($signed(cur) > $signed(rdata)) begin
          we       = 1'b1;
          waddr    = AW'(j);
          wdata    = cur;
          cur_next = rdata;
        end
        j_next = j + 1'b1;
        if (j + 1'b1 == cnt) begin
          state_next = ST_SRT_PUT;
        end else begin
          re    = 1'b1;
          raddr = AW'(j + 1'b1);
        end
      end
      ST_SRT_PUT: begin
        we     = 1'b1;
        waddr  = AW'(i);
        wdata  = cur;
        i_next = i + 1'b1;
        if (i + 2'd2 == cnt) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          re         = 1'b1;
          raddr      = AW'(i + 1'b1);
          state_next = ST_SRT_LDI;
        end
      end
      // one entry per result, stalled by the output register
      ST_DMP_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_has  = 1'b1;
          out_elem = rdata;
          out_idx  = IDX_W'(CMPW'(i));
          out_last = (i + 1'b1 == cnt);
          i_next   = i + 1'b1;
          if (i + 1'b1 == cnt) begin
            state_next = ST_IDLE;
          end else begin
            re    = 1'b1;
            raddr = AW'(i + 1'b1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      o_acc  <= out_acc;
      o_full <= out_full;
      o_has  <= out_has;
      o_elem <= out_elem;
      o_idx  <= out_idx;
      o_last <= out_last;
      o_cnt  <= COUNT_W'(CMPW'(cnt_next));
    end
  end

  assign m_tdata = {4'd0, o_cnt, o_idx, o_elem, o_has, o_full, o_acc};
  assign m_tlast = o_last;

  // checks
  `PLE_ASSERT(a_cnt_range, cnt <= CW'(DEPTH), "entry count above depth")
  `PLE_ASSERT(a_ready_idle, !s_tready || state == ST_IDLE, "ready outside idle")
  `PLE_ASSERT_NEXT(a_cnt_step, cnt != cnt_next,
    (cnt == $past(cnt) + 1'b1) || (cnt + 1'b1 == $past(cnt)), "count moved by more than one")
  `PLE_ASSERT_NEXT(a_full_refuse, s_tvalid && s_tready && in_kind == K_INSERT && cnt == CW'(DEPTH),
    m_tvalid && !m_tdata[0] && m_tdata[1], "full insert not flagged")

endmodule

// ===== tb/tb_top.sv =====
// testbench for the positional list engine: directed and random list operations
// predicts every result from a local copy of the list; depends on ple_pkg and the rtl
module tb_top;
  import ple_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic        accepted;
    logic        full_res;
    logic        has_element;
    logic [31:0] element;
    logic [3:0]  index;
    logic [4:0]  count;
    logic        last;
  } list_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  logic signed [31:0] model_list [DEPTH];
  int unsigned        model_count;
  list_res_t          pending_results [$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 calm = 0;

  positional_list_engine #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // push one result onto the expectation queue
  function automatic void push_res(logic acc, logic full, logic has, logic [31:0] elem,
                                   logic [3:0] idx, logic lst);
    list_res_t r;
    r.accepted = acc; r.full_res = full; r.has_element = has;
    r.element = elem; r.index = idx; r.count = model_count[4:0]; r.last = lst;
    pending_results.push_back(r);
  endfunction

  // apply one operation to the local list
  function automatic void predict_op(kind_t kind, logic [4:0] pos, logic signed [31:0] val);
    logic signed [31:0] t;
    case (kind)
      K_INSERT: begin
        if (model_count >= DEPTH) push_res(0, 1, 0, 0, 0, 1);
        else if (pos > model_count) push_res(0, 0, 0, 0, 0, 1);
        else begin
          for (int i = model_count; i > pos; i--) model_list[i] = model_list[i-1];
          model_list[pos] = val;
          model_count++;
          push_res(1, 0, 0, 0, 0, 1);
        end
      end
      K_ERASE: begin
        if (pos >= model_count) push_res(0, 0, 0, 0, 0, 1);
        else begin
          for (int i = pos; i + 1 < model_count; i++) model_list[i] = model_list[i+1];
          model_count--;
          push_res(1, 0, 0, 0, 0, 1);
        end
      end
      K_SORT: begin
        for (int i = 0; i < model_count; i++)
          for (int j = i + 1; j < model_count; j++)
            if (model_list[i] > model_list[j]) begin
              t = model_list[i]; model_list[i] = model_list[j]; model_list[j] = t;
            end
        push_res(1, 0, 0, 0, 0, 1);
      end
      default: begin
        if (model_count == 0) push_res(1, 0, 0, 0, 0, 1);
        else
          for (int i = 0; i < model_count; i++)
            push_res(1, 0, 1, model_list[i], i[3:0], i + 1 == model_count);
      end
    endcase
  endfunction

  // send one item, with random idle cycles before it
  task automatic send_item(kind_t kind, logic [4:0] pos, logic [31:0] val);
    while (!calm && $urandom_range(99) < 13) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_op(kind, pos, val);
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(99) >= 13);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    list_res_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[34:3], m_tdata[38:35],
             m_tdata[43:39], m_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected acc=%b full=%b has=%b elem=%h idx=%0d cnt=%0d last=%b",
                   $time, exp.accepted, exp.full_res, exp.has_element, exp.element,
                   exp.index, exp.count, exp.last);
          $display("%0t:          actual   acc=%b full=%b has=%b elem=%h idx=%0d cnt=%0d last=%b",
                   $time, got.accepted, got.full_res, got.has_element, got.element,
                   got.index, got.count, got.last);
          errors++;
        end
      end
    end
  end

  // stop sending and wait for every expected result
  task automatic wait_drained();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // extremes, refusals, full list, empty dump
  task automatic test_directed();
    send_item(K_DUMP, 0, 0);
    send_item(K_ERASE, 0, 0);
    send_item(K_INSERT, 1, 32'h1);
    send_item(K_INSERT, 0, 32'h7fffffff);
    send_item(K_INSERT, 0, 32'h80000000);
    send_item(K_INSERT, 2, 32'hffffffff);
    send_item(K_INSERT, 31, 32'h0);
    send_item(K_SORT, 0, 0);
    send_item(K_DUMP, 31, 32'hffffffff);
    for (int i = 3; i < DEPTH; i++) send_item(K_INSERT, i[4:0], $urandom);
    send_item(K_INSERT, 16, 32'h5);
    send_item(K_INSERT, 0, 32'h5);
    send_item(K_SORT, 0, 0);
    send_item(K_DUMP, 0, 0);
    send_item(K_ERASE, 16, 0);
    send_item(K_ERASE, 15, 0);
    send_item(K_ERASE, 0, 0);
  endtask

  // random mixes, mostly in-range positions
  task automatic test_random(int n);
    kind_t k;
    logic [4:0] p;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = r < 45 ? K_INSERT : r < 80 ? K_ERASE : r < 90 ? K_SORT : K_DUMP;
      if ($urandom_range(9) == 0) p = 5'($urandom);
      else p = 5'($urandom_range(model_count));
      if (k == K_ERASE && model_count < 3 && $urandom_range(1)) k = K_INSERT;
      send_item(k, p, $urandom);
    end
  endtask

  // flat-out traffic with no idling
  task automatic test_no_idle();
    calm = 1;
    test_random(60);
    wait_drained();
    calm = 0;
  endtask

  initial begin
    model_count = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(130);
    wait_drained();
    test_no_idle();
    test_random(130);
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
